/* src/one_wire_bus_master_defines.svh */
// ----------------------------------------------------------------------------
// one_wire_bus_master_defines
// assertion macros shared by the one-wire bus master rtl
// ----------------------------------------------------------------------------
`ifndef ONE_WIRE_BUS_MASTER_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define OWBM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("one-wire bus master check failed");

// next-cycle implication, checked out of reset
`define OWBM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("one-wire bus master check failed");

`endif

/* src/owbm_pkg.sv */
// ----------------------------------------------------------------------------
// owbm_pkg
// types, register defaults and phase sequencing for the one-wire bus master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owbm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_R_LOW    = 4'd1,
    PH_R_SAMPLE = 4'd2,
    PH_R_POLL   = 4'd3,
    PH_R_TAIL   = 4'd4,
    PH_W_START  = 4'd5,
    PH_W_HOLD   = 4'd6,
    PH_W_TAIL   = 4'd7,
    PH_D_START  = 4'd8,
    PH_D_SAMPLE = 4'd9,
    PH_D_WAIT   = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_RESET = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_RESET_LOW  = 3'd0,
    CFG_POLL_US    = 3'd1,
    CFG_POLLS      = 3'd2,
    CFG_TAIL_US    = 3'd3,
    CFG_START_LOW  = 3'd4,
    CFG_WRITE_SLOT = 3'd5,
    CFG_WRITE_TAIL = 3'd6,
    CFG_READ_SLOT  = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned TimerW   = 10;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [9:0] RstResetLow  = 10'd640;
  localparam logic [9:0] RstPollUs    = 10'd640;
  localparam logic [3:0] RstPolls     = 4'd5;
  localparam logic [9:0] RstTailUs    = 10'd500;
  localparam logic [3:0] RstStartLow  = 4'd1;
  localparam logic [7:0] RstWriteSlot = 8'd87;
  localparam logic [7:0] RstWriteTail = 8'd58;
  localparam logic [7:0] RstReadSlot  = 8'd63;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [9:0] poll_us;
    logic [3:0] polls;
    logic [9:0] tail_us;
    logic [3:0] start_low;
    logic [7:0] write_slot;
    logic [7:0] write_tail;
    logic [7:0] read_slot;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [TimerW-1:0] timer;
    logic [2:0]        bit_cnt;
    logic [7:0]        shift;
    logic [3:0]        poll;
    logic              present;
    logic [7:0]        last_rd;
  } st_t;

  // enter phase p, passing straight through phases of zero length
  function automatic st_t enter_f(phase_e p, st_t s, cfg_t c);
    st_t        r;
    logic [3:0] sh_amt;
    r      = s;
    sh_amt = 4'd8 - {1'b0, s.bit_cnt};
    r.phase = PH_IDLE;
    r.timer = '0;
    unique case (p)
      PH_IDLE: begin
        r.phase = PH_IDLE;
      end
      PH_R_LOW: begin
        if (c.reset_low != '0) begin
          r.phase = PH_R_LOW;
          r.timer = c.reset_low;
        end else begin
          r.phase = PH_R_SAMPLE;
          r.timer = 10'd1;
        end
      end
      PH_R_SAMPLE: begin
        r.phase = PH_R_SAMPLE;
        r.timer = 10'd1;
      end
      PH_R_POLL: begin
        if (c.poll_us != '0) begin
          r.phase = PH_R_POLL;
          r.timer = c.poll_us;
        end else if (s.poll >= c.polls) begin
          r.present = 1'b0;
        end else begin
          r.poll  = s.poll + 4'd1;
          r.phase = PH_R_SAMPLE;
          r.timer = 10'd1;
        end
      end
      PH_R_TAIL: begin
        if (c.tail_us != '0) begin
          r.phase = PH_R_TAIL;
          r.timer = c.tail_us;
        end
      end
      PH_W_START, PH_W_HOLD: begin
        if (p == PH_W_START && c.start_low != '0) begin
          r.phase = PH_W_START;
          r.timer = {6'd0, c.start_low};
        end else if (c.write_slot != '0) begin
          r.phase = PH_W_HOLD;
          r.timer = {2'd0, c.write_slot};
        end else if (c.start_low == '0) begin
          // whole byte runs out with no time spent
          r.shift   = s.shift >> sh_amt;
          r.bit_cnt = '0;
          if (c.write_tail != '0) begin
            r.phase = PH_W_TAIL;
            r.timer = {2'd0, c.write_tail};
          end
        end else begin
          r.shift = s.shift >> 1;
          if (s.bit_cnt == 3'd7) begin
            r.bit_cnt = '0;
            if (c.write_tail != '0) begin
              r.phase = PH_W_TAIL;
              r.timer = {2'd0, c.write_tail};
            end
          end else begin
            r.bit_cnt = s.bit_cnt + 3'd1;
            r.phase   = PH_W_START;
            r.timer   = {6'd0, c.start_low};
          end
        end
      end
      PH_W_TAIL: begin
        if (c.write_tail != '0) begin
          r.phase = PH_W_TAIL;
          r.timer = {2'd0, c.write_tail};
        end
      end
      PH_D_START: begin
        if (c.start_low != '0) begin
          r.phase = PH_D_START;
          r.timer = {6'd0, c.start_low};
        end else begin
          r.phase = PH_D_SAMPLE;
          r.timer = 10'd1;
        end
      end
      PH_D_SAMPLE: begin
        r.phase = PH_D_SAMPLE;
        r.timer = 10'd1;
      end
      PH_D_WAIT: begin
        if (c.read_slot != '0) begin
          r.phase = PH_D_WAIT;
          r.timer = {2'd0, c.read_slot};
        end else if (s.bit_cnt == 3'd7) begin
          r.bit_cnt = '0;
          r.last_rd = s.shift;
        end else begin
          r.bit_cnt = s.bit_cnt + 3'd1;
          if (c.start_low != '0) begin
            r.phase = PH_D_START;
            r.timer = {6'd0, c.start_low};
          end else begin
            r.phase = PH_D_SAMPLE;
            r.timer = 10'd1;
          end
        end
      end
      default: begin
        r.phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // end of the current phase: state update, phase field holds the next phase
  function automatic st_t finish_f(st_t s, logic line, cfg_t c);
    st_t r;
    r = s;
    r.phase = PH_IDLE;
    unique case (s.phase)
      PH_R_LOW: r.phase = PH_R_SAMPLE;
      PH_R_SAMPLE: begin
        if (!line) begin
          r.present = 1'b1;
          r.phase   = PH_R_TAIL;
        end else begin
          r.phase = PH_R_POLL;
        end
      end
      PH_R_POLL: begin
        if (s.poll >= c.polls) begin
          r.present = 1'b0;
        end else begin
          r.poll  = s.poll + 4'd1;
          r.phase = PH_R_SAMPLE;
        end
      end
      PH_W_START: r.phase = PH_W_HOLD;
      PH_W_HOLD: begin
        r.shift = s.shift >> 1;
        if (s.bit_cnt == 3'd7) begin
          r.bit_cnt = '0;
          r.phase   = PH_W_TAIL;
        end else begin
          r.bit_cnt = s.bit_cnt + 3'd1;
          r.phase   = PH_W_START;
        end
      end
      PH_D_START: r.phase = PH_D_SAMPLE;
      PH_D_SAMPLE: begin
        r.shift = {line, s.shift[7:1]};
        r.phase = PH_D_WAIT;
      end
      PH_D_WAIT: begin
        if (s.bit_cnt == 3'd7) begin
          r.bit_cnt = '0;
          r.last_rd = s.shift;
        end else begin
          r.bit_cnt = s.bit_cnt + 3'd1;
          r.phase   = PH_D_START;
        end
      end
      default: r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

endpackage

/* src/one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// one_wire_bus_master
// single-wire bus master stepped once per microsecond item: bus reset with
// presence detect, byte write and byte read, lsb first
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// s_axis   in   tvalid/tready         tuser kind, tdata byte_in, line_in
// m_axis   out  tvalid/tready         tdata drive_low, busy, done, present, byte_out
// cfg      in   cfg_we_i, no wait     cfg_idx_i, cfg_data_i
//
// one item a cycle sustained while the result side is not stalled; a taken item
// passes the input register, then the phase update writes its result into the
// result register
// all bus timing is counted in items, the phase counter is the only loop
// reset clears the phase state and the stage valids and loads the default timing
// a stalled result holds the input stage; ready stays high while either
// register has room
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "one_wire_bus_master_defines.svh"

module one_wire_bus_master (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [owbm_pkg::InDataW-1:0]    s_axis_tdata,  // byte_in, line_in, zero pad
  input  logic [1:0]                      s_axis_tuser,  // kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // drive_low, busy_res, done_res, present, byte_out, zero pad
  output logic [owbm_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [owbm_pkg::CfgDataW-1:0]   cfg_data_i
);

  owbm_pkg::cfg_t   cfg_q;
  owbm_pkg::st_t    st_q, st_d, st_cmd, st_a, st_b, st_fin;
  owbm_pkg::phase_e cmd_phase;

  logic       s0_valid_q;
  logic [1:0] s0_kind_q;
  logic [7:0] s0_byte_q;
  logic       s0_line_q;

  logic                           m_valid_q;
  logic [owbm_pkg::OutDataW-1:0]  res_q, res_d;
  logic                           adv;
  logic                           drive, busy, done;
  logic [owbm_pkg::TimerW-1:0]    timer_dec;

  assign adv           = s0_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s0_valid_q || adv;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low  <= owbm_pkg::RstResetLow;
      cfg_q.poll_us    <= owbm_pkg::RstPollUs;
      cfg_q.polls      <= owbm_pkg::RstPolls;
      cfg_q.tail_us    <= owbm_pkg::RstTailUs;
      cfg_q.start_low  <= owbm_pkg::RstStartLow;
      cfg_q.write_slot <= owbm_pkg::RstWriteSlot;
      cfg_q.write_tail <= owbm_pkg::RstWriteTail;
      cfg_q.read_slot  <= owbm_pkg::RstReadSlot;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        owbm_pkg::CFG_RESET_LOW:  cfg_q.reset_low  <= cfg_data_i;
        owbm_pkg::CFG_POLL_US:    cfg_q.poll_us    <= cfg_data_i;
        owbm_pkg::CFG_POLLS:      cfg_q.polls      <= cfg_data_i[3:0];
        owbm_pkg::CFG_TAIL_US:    cfg_q.tail_us    <= cfg_data_i;
        owbm_pkg::CFG_START_LOW:  cfg_q.start_low  <= cfg_data_i[3:0];
        owbm_pkg::CFG_WRITE_SLOT: cfg_q.write_slot <= cfg_data_i[7:0];
        owbm_pkg::CFG_WRITE_TAIL: cfg_q.write_tail <= cfg_data_i[7:0];
        owbm_pkg::CFG_READ_SLOT:  cfg_q.read_slot  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s0_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s0_kind_q <= s_axis_tuser;
      s0_byte_q <= s_axis_tdata[7:0];
      s0_line_q <= s_axis_tdata[8];
    end
  end

  // one tick of the bus sequencer
  always_comb begin
    st_cmd         = st_q;
    st_cmd.bit_cnt = '0;
    st_cmd.poll    = '0;
    cmd_phase      = owbm_pkg::PH_IDLE;
    unique case (s0_kind_q)
      owbm_pkg::KIND_RESET: cmd_phase = owbm_pkg::PH_R_LOW;
      owbm_pkg::KIND_WRITE: begin
        cmd_phase    = owbm_pkg::PH_W_START;
        st_cmd.shift = s0_byte_q;
      end
      owbm_pkg::KIND_READ: begin
        cmd_phase    = owbm_pkg::PH_D_START;
        st_cmd.shift = '0;
      end
      default: cmd_phase = owbm_pkg::PH_IDLE;
    endcase

    st_a = st_q;
    done = 1'b0;
    if (st_q.phase == owbm_pkg::PH_IDLE &&
        s0_kind_q != owbm_pkg::KIND_TICK) begin
      st_a = owbm_pkg::enter_f(cmd_phase, st_cmd, cfg_q);
      done = (st_a.phase == owbm_pkg::PH_IDLE);
    end

    busy      = 1'b0;
    drive     = 1'b0;
    timer_dec = (st_a.timer != '0) ? st_a.timer - 10'd1 : '0;
    st_b      = st_a;
    st_b.timer = timer_dec;
    st_fin    = owbm_pkg::finish_f(st_b, s0_line_q, cfg_q);
    st_d      = st_a;
    if (st_a.phase != owbm_pkg::PH_IDLE) begin
      busy = 1'b1;
      case (st_a.phase) inside
        owbm_pkg::PH_R_LOW, owbm_pkg::PH_W_START, owbm_pkg::PH_D_START: drive = 1'b1;
        owbm_pkg::PH_W_HOLD: drive = !st_a.shift[0];
        default: drive = 1'b0;
      endcase
      if (timer_dec == '0) begin
        st_d = owbm_pkg::enter_f(st_fin.phase, st_fin, cfg_q);
        done = (st_d.phase == owbm_pkg::PH_IDLE);
      end else begin
        st_d = st_b;
      end
    end

    res_d = {4'd0, st_d.last_rd, st_d.present, done, busy, drive};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: owbm_pkg::PH_IDLE, default: '0};
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (!m_valid_q || m_axis_tready) begin
      m_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  `OWBM_ASSERT_IMP(a_idle_timer_clear, st_q.phase == owbm_pkg::PH_IDLE, st_q.timer == '0)
  `OWBM_ASSERT_IMP(a_sample_one_tick,
    st_q.phase == owbm_pkg::PH_R_SAMPLE || st_q.phase == owbm_pkg::PH_D_SAMPLE,
    st_q.timer == 10'd1)
  `OWBM_ASSERT_IMP(a_drive_only_busy, m_valid_q && res_q[0], res_q[1])
  `OWBM_ASSERT_NXT(a_tick_keeps_idle,
    adv && st_q.phase == owbm_pkg::PH_IDLE && s0_kind_q == owbm_pkg::KIND_TICK,
    st_q.phase == owbm_pkg::PH_IDLE)

endmodule

/* tb/tb_one_wire_bus_master.sv */
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// self-checking bench for the one-wire bus master. a cycle-level model of the
// slot timing predicts every result item. a short table of bus resets, byte
// writes and byte reads runs first, including zero-length phases and the empty
// write. random operations follow, with random line levels and stray commands,
// over many timing settings. both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_one_wire_bus_master;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned ItemTarget = 750;

  typedef struct packed {
    logic       drive_low;
    logic       busy;
    logic       done;
    logic       present;
    logic [7:0] rd_byte;
  } line_res_t;

  typedef struct packed {
    logic               is_cfg;
    owbm_pkg::cfg_idx_e idx;
    logic [9:0]         val;
    owbm_pkg::kind_e    kind;
    logic [7:0]         data;
    logic               line;
    logic               settle;
    logic               chk;
    line_res_t          want;
  } dir_row_t;

  localparam line_res_t ResIdle       = '0;
  localparam line_res_t ResResetOpen  = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
  localparam line_res_t ResEmptyWrite = '{1'b0, 1'b0, 1'b1, 1'b1, 8'h00};

  localparam dir_row_t DirTab [33] = '{
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_TICK,  8'h00, 1'b1,
      1'b0, 1'b1, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_TICK,  8'hff, 1'b0,
      1'b0, 1'b1, ResIdle},
    '{1'b1, owbm_pkg::CFG_RESET_LOW,  10'd2,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_POLL_US,    10'd1,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_POLLS,      10'd1,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_TAIL_US,    10'd1,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_START_LOW,  10'd1,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_WRITE_SLOT, 10'd1,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_WRITE_TAIL, 10'd0,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_READ_SLOT,  10'd0,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_RESET, 8'h00, 1'b1,
      1'b0, 1'b1, ResResetOpen},
    // commands while busy are dropped
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_WRITE, 8'hff, 1'b1,
      1'b0, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_RESET, 8'h00, 1'b1,
      1'b1, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_RESET, 8'h00, 1'b0,
      1'b1, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_WRITE, 8'h00, 1'b1,
      1'b1, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_WRITE, 8'hff, 1'b1,
      1'b1, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_READ,  8'h00, 1'b1,
      1'b1, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_READ,  8'h00, 1'b0,
      1'b1, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_START_LOW,  10'd0,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_WRITE_SLOT, 10'd0,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_WRITE_TAIL, 10'd0,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    // write with every phase of zero length
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_WRITE, 8'ha5, 1'b1,
      1'b1, 1'b1, ResEmptyWrite},
    '{1'b1, owbm_pkg::CFG_WRITE_TAIL, 10'd3,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_WRITE, 8'h5a, 1'b1,
      1'b1, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_POLL_US,    10'd0,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_RESET, 8'h00, 1'b1,
      1'b1, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_READ,  8'h00, 1'b1,
      1'b1, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_START_LOW,  10'd15, owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b1, owbm_pkg::CFG_TAIL_US,    10'd0,  owbm_pkg::KIND_TICK,  8'h00, 1'b0,
      1'b0, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_WRITE, 8'h3c, 1'b1,
      1'b1, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_RESET, 8'h00, 1'b0,
      1'b1, 1'b0, ResIdle},
    '{1'b0, owbm_pkg::CFG_RESET_LOW,  10'd0,  owbm_pkg::KIND_READ,  8'h00, 1'b0,
      1'b1, 1'b0, ResIdle}
  };

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [owbm_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]                    s_axis_tuser  = owbm_pkg::KIND_TICK;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [owbm_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          cfg_we_i      = 1'b0;
  logic [owbm_pkg::CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [owbm_pkg::CfgDataW-1:0] cfg_data_i    = '0;

  // timing registers as the master sees them
  logic [9:0] cfg_reset_low = owbm_pkg::RstResetLow;
  logic [9:0] cfg_poll_us   = owbm_pkg::RstPollUs;
  logic [3:0] cfg_polls     = owbm_pkg::RstPolls;
  logic [9:0] cfg_tail_us   = owbm_pkg::RstTailUs;
  logic [3:0] cfg_start_low = owbm_pkg::RstStartLow;
  logic [7:0] cfg_wr_slot   = owbm_pkg::RstWriteSlot;
  logic [7:0] cfg_wr_tail   = owbm_pkg::RstWriteTail;
  logic [7:0] cfg_rd_slot   = owbm_pkg::RstReadSlot;

  // bus sequencer state
  owbm_pkg::phase_e master_phase = owbm_pkg::PH_IDLE;
  logic [9:0]       slot_timer   = '0;
  logic [2:0]       bit_idx      = '0;
  logic [7:0]       shift_reg    = '0;
  logic [3:0]       poll_idx     = '0;
  logic             present_q    = 1'b0;
  logic [7:0]       rd_byte_q    = '0;

  line_res_t bus_result_q [$];

  int unsigned cycles     = 0;
  int unsigned n_err      = 0;
  int unsigned n_checked  = 0;
  int unsigned n_items    = 0;
  int unsigned n_ops      = 0;
  int unsigned n_settings = 0;
  int unsigned snk_hold   = 0;
  logic        src_calm   = 1'b0;
  logic        snk_calm   = 1'b0;

  one_wire_bus_master dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // byte_in, line_in, zero pad
    .s_axis_tuser  (s_axis_tuser),   // kind
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // drive_low, busy, done, present, byte_out, zero pad
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic owbm_pkg::phase_e phase_end(owbm_pkg::phase_e p, logic ln);
    owbm_pkg::phase_e nxt;
    nxt = owbm_pkg::PH_IDLE;
    case (p)
      owbm_pkg::PH_R_LOW:    nxt = owbm_pkg::PH_R_SAMPLE;
      owbm_pkg::PH_R_SAMPLE: begin
        if (!ln) begin
          present_q = 1'b1;
          nxt = owbm_pkg::PH_R_TAIL;
        end else begin
          nxt = owbm_pkg::PH_R_POLL;
        end
      end
      owbm_pkg::PH_R_POLL: begin
        if (poll_idx >= cfg_polls) begin
          present_q = 1'b0;
        end else begin
          poll_idx = poll_idx + 4'd1;
          nxt = owbm_pkg::PH_R_SAMPLE;
        end
      end
      owbm_pkg::PH_W_START:  nxt = owbm_pkg::PH_W_HOLD;
      owbm_pkg::PH_W_HOLD: begin
        shift_reg = shift_reg >> 1;
        if (bit_idx == 3'd7) begin
          bit_idx = '0;
          nxt = owbm_pkg::PH_W_TAIL;
        end else begin
          bit_idx = bit_idx + 3'd1;
          nxt = owbm_pkg::PH_W_START;
        end
      end
      owbm_pkg::PH_D_START:  nxt = owbm_pkg::PH_D_SAMPLE;
      owbm_pkg::PH_D_SAMPLE: begin
        shift_reg = {ln, shift_reg[7:1]};
        nxt = owbm_pkg::PH_D_WAIT;
      end
      owbm_pkg::PH_D_WAIT: begin
        if (bit_idx == 3'd7) begin
          bit_idx = '0;
          rd_byte_q = shift_reg;
        end else begin
          bit_idx = bit_idx + 3'd1;
          nxt = owbm_pkg::PH_D_START;
        end
      end
      default: nxt = owbm_pkg::PH_IDLE;
    endcase
    return nxt;
  endfunction

  // zero-length phases end at once, as if the line were high
  function automatic void phase_begin(owbm_pkg::phase_e p);
    logic [9:0] len;
    logic       placed;
    placed = 1'b0;
    while (!placed) begin
      case (p)
        owbm_pkg::PH_R_LOW:   len = cfg_reset_low;
        owbm_pkg::PH_R_POLL:  len = cfg_poll_us;
        owbm_pkg::PH_R_TAIL:  len = cfg_tail_us;
        owbm_pkg::PH_W_START, owbm_pkg::PH_D_START:   len = {6'd0, cfg_start_low};
        owbm_pkg::PH_W_HOLD:  len = {2'd0, cfg_wr_slot};
        owbm_pkg::PH_W_TAIL:  len = {2'd0, cfg_wr_tail};
        owbm_pkg::PH_D_WAIT:  len = {2'd0, cfg_rd_slot};
        owbm_pkg::PH_R_SAMPLE, owbm_pkg::PH_D_SAMPLE: len = 10'd1;
        default:              len = '0;
      endcase
      if (p == owbm_pkg::PH_IDLE || len != '0) begin
        master_phase = p;
        slot_timer   = len;
        placed       = 1'b1;
      end else begin
        p = phase_end(p, 1'b1);
      end
    end
  endfunction

  function automatic line_res_t master_tick(owbm_pkg::kind_e k, logic [7:0] b, logic ln);
    line_res_t r;
    r = '0;
    if (master_phase == owbm_pkg::PH_IDLE && k != owbm_pkg::KIND_TICK) begin
      n_ops++;
      bit_idx  = '0;
      poll_idx = '0;
      case (k)
        owbm_pkg::KIND_RESET: phase_begin(owbm_pkg::PH_R_LOW);
        owbm_pkg::KIND_WRITE: begin
          shift_reg = b;
          phase_begin(owbm_pkg::PH_W_START);
        end
        default: begin
          shift_reg = '0;
          phase_begin(owbm_pkg::PH_D_START);
        end
      endcase
      if (master_phase == owbm_pkg::PH_IDLE) r.done = 1'b1;
    end
    if (master_phase != owbm_pkg::PH_IDLE) begin
      r.busy = 1'b1;
      r.drive_low = (master_phase == owbm_pkg::PH_R_LOW) ||
                    (master_phase == owbm_pkg::PH_W_START) ||
                    (master_phase == owbm_pkg::PH_D_START) ||
                    (master_phase == owbm_pkg::PH_W_HOLD && !shift_reg[0]);
      if (slot_timer != '0) slot_timer = slot_timer - 10'd1;
      if (slot_timer == '0) begin
        phase_begin(phase_end(master_phase, ln));
        if (master_phase == owbm_pkg::PH_IDLE) r.done = 1'b1;
      end
    end
    r.present = present_q;
    r.rd_byte = rd_byte_q;
    return r;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(2, 4);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic line_pick(int mode);
    case (mode)
      0:       return 1'($urandom_range(0, 1));
      1:       return $urandom_range(0, 7) != 0;
      2:       return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(string what, logic [7:0] want, logic [7:0] got);
    n_err++;
    $display("%0t: %s expected %h got %h", $time, what, want, got);
  endtask

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) report(what, want, got);
  endtask

  task automatic send_item(owbm_pkg::kind_e k, logic [7:0] b, logic ln, logic typed,
                           line_res_t typed_res);
    int        gap;
    line_res_t pred;
    gap = 0;
    if (!src_calm && $urandom_range(0, 2) == 0) gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {7'd0, ln, b};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    pred = master_tick(k, b, ln);
    bus_result_q.push_back(typed ? typed_res : pred);
    n_items++;
  endtask

  task automatic finish_op(logic ln, int mode, logic noisy);
    owbm_pkg::kind_e k;
    while (master_phase != owbm_pkg::PH_IDLE) begin
      k = owbm_pkg::KIND_TICK;
      if (noisy && $urandom_range(0, 9) == 0) k = owbm_pkg::kind_e'($urandom_range(1, 3));
      send_item(k, 8'($urandom), (mode < 0) ? ln : line_pick(mode), 1'b0, ResIdle);
    end
  endtask

  task automatic settle_results();
    s_axis_tvalid <= 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(owbm_pkg::cfg_idx_e idx, logic [9:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      owbm_pkg::CFG_RESET_LOW:  cfg_reset_low = val;
      owbm_pkg::CFG_POLL_US:    cfg_poll_us   = val;
      owbm_pkg::CFG_POLLS:      cfg_polls     = val[3:0];
      owbm_pkg::CFG_TAIL_US:    cfg_tail_us   = val;
      owbm_pkg::CFG_START_LOW:  cfg_start_low = val[3:0];
      owbm_pkg::CFG_WRITE_SLOT: cfg_wr_slot   = val[7:0];
      owbm_pkg::CFG_WRITE_TAIL: cfg_wr_tail   = val[7:0];
      owbm_pkg::CFG_READ_SLOT:  cfg_rd_slot   = val[7:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // 2 all zero, otherwise short
  task automatic load_timing(int mode);
    logic [9:0] v;
    for (int i = 0; i < 8; i++) begin
      if (mode == 2) begin
        v = '0;
      end else if (owbm_pkg::cfg_idx_e'(i) == owbm_pkg::CFG_POLLS) begin
        v = 10'($urandom_range(0, 3));
      end else begin
        v = 10'($urandom_range(0, 6));
      end
      cfg_write(owbm_pkg::cfg_idx_e'(i), v);
    end
    n_settings++;
  endtask

  task automatic run_op();
    int mode;
    repeat ($urandom_range(0, 2)) begin
      send_item(owbm_pkg::KIND_TICK, 8'($urandom), 1'($urandom), 1'b0, ResIdle);
    end
    mode = $urandom_range(0, 3);
    send_item(owbm_pkg::kind_e'($urandom_range(1, 3)), 8'($urandom), line_pick(mode),
              1'b0, ResIdle);
    finish_op(1'b1, mode, 1'b1);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 600 == 0) begin
      src_calm <= ($urandom_range(0, 3) == 0);
      snk_calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    line_res_t got;
    line_res_t want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
      got.drive_low = m_axis_tdata[0];
      got.busy      = m_axis_tdata[1];
      got.done      = m_axis_tdata[2];
      got.present   = m_axis_tdata[3];
      got.rd_byte   = m_axis_tdata[11:4];
      if (bus_result_q.size() == 0) begin
        report("unexpected item", 8'h00, m_axis_tdata[7:0]);
      end else begin
        want = bus_result_q.pop_front();
        check_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
        check_field("busy", 8'(want.busy), 8'(got.busy));
        check_field("done", 8'(want.done), 8'(got.done));
        check_field("present", 8'(want.present), 8'(got.present));
        check_field("byte_out", want.rd_byte, got.rd_byte);
        n_checked++;
      end
    end
    if (snk_hold > 0) begin
      m_axis_tready <= 1'b0;
      snk_hold = snk_hold - 1;
    end else if (!snk_calm && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      snk_hold = gap_len() - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    int mode;
    int phase_no;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      if (DirTab[i].is_cfg) begin
        settle_results();
        cfg_write(DirTab[i].idx, DirTab[i].val);
      end else begin
        send_item(DirTab[i].kind, DirTab[i].data, DirTab[i].line, DirTab[i].chk,
                  DirTab[i].want);
        if (DirTab[i].settle) finish_op(DirTab[i].line, -1, 1'b0);
      end
    end

    phase_no = 0;
    while (n_items < ItemTarget) begin
      settle_results();
      mode = (phase_no % 4 == 3) ? 2 : 3;
      load_timing(mode);
      for (int j = 0; j < 8 && n_items < ItemTarget; j++) run_op();
      phase_no++;
    end

    settle_results();
    $display("%0d bus operations in %0d items over %0d timing settings",
             n_ops, n_items, n_settings + 1);
    $display("%0d result items compared, %0d mismatches", n_checked, n_err);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* one_wire_bus_master.f */
+incdir+src
src/owbm_pkg.sv
src/one_wire_bus_master.sv
tb/tb_one_wire_bus_master.sv
